// ===== rtl/core/clt_pkg.sv =====
// types, codes and constants shared by the connection liveness tracker
`timescale 1ns / 1ps

package clt_pkg;

  localparam int NUM_CONNS_DEF = 1024;

  localparam int INDEX_W = 10;
  localparam int TIME_W = 32;
  localparam int BACKEND_W = 16;
  localparam int SEQ_W = 32;
  localparam int CFG_W = 16;
  localparam int OPEN_W = 11;
  localparam int CNT_W = 32;

  // commands
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_DONE = 3'd1;
  localparam logic [2:0] CMD_ERROR = 3'd2;
  localparam logic [2:0] CMD_REPLY = 3'd3;
  localparam logic [2:0] CMD_BREAK = 3'd4;
  localparam logic [2:0] CMD_SCAN = 3'd5;

  // connection phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CONNECTING = 3'd1;
  localparam logic [2:0] PH_OPEN = 3'd2;
  localparam logic [2:0] PH_BROKEN = 3'd3;
  localparam logic [2:0] PH_FAILED = 3'd4;

  // result actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_BEAT = 2'd1;
  localparam logic [1:0] ACT_BROKEN = 2'd2;
  localparam logic [1:0] ACT_FAILED = 2'd3;

  // break causes
  localparam logic [1:0] CAUSE_RST = 2'd0;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
  localparam logic [1:0] CAUSE_WRONG_BACKEND = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_HB_INTERVAL = 2'd0;
  localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_CONNECT_TIMEOUT = 2'd2;

  localparam logic [CFG_W-1:0] HB_INTERVAL_RST = 16'd100;
  localparam logic [CFG_W-1:0] REPLY_TIMEOUT_RST = 16'd2000;
  localparam logic [CFG_W-1:0] CONNECT_TIMEOUT_RST = 16'd5000;

  localparam logic [OPEN_W-1:0] OPEN_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [2:0] phase;
    logic backend_valid;
    logic hb_outstanding;
    logic [BACKEND_W-1:0] backend;
    logic [TIME_W-1:0] time_mark;
    logic [TIME_W-1:0] next_beat;
    logic [SEQ_W-1:0] beat_counter;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] hb_interval;
    logic [CFG_W-1:0] reply_timeout;
    logic [CFG_W-1:0] connect_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] cause;
    logic [SEQ_W-1:0] seq;
    logic open_inc;
    logic open_dec;
    logic brk;
  } upd_t;

endpackage

// ===== rtl/core/clt_entry_update.sv =====
// next-state logic for one connection entry and one command
`timescale 1ns / 1ps

module clt_entry_update (
  input  logic [2:0]                    cmd,
  input  logic [clt_pkg::TIME_W-1:0]    now_ms,
  input  logic [clt_pkg::BACKEND_W-1:0] reply_backend,
  input  logic [1:0]                    break_cause,
  input  clt_pkg::cfg_t                 cfg,
  input  clt_pkg::entry_t               entry,
  output clt_pkg::entry_t               entry_next,
  output clt_pkg::upd_t                 upd
);
  import clt_pkg::*;

  logic [TIME_W-1:0] d_mark;
  logic [TIME_W-1:0] d_beat;
  logic connect_expired;
  logic reply_expired;
  logic beat_due;
  logic [SEQ_W-1:0] seq_inc;

  // elapsed time counts only while the difference is below half the range
  assign d_mark = now_ms - entry.time_mark;
  assign d_beat = now_ms - entry.next_beat;
  assign connect_expired = !d_mark[TIME_W-1]
                           && (d_mark > {{(TIME_W-CFG_W){1'b0}}, cfg.connect_timeout});
  assign reply_expired = !d_mark[TIME_W-1]
                         && (d_mark > {{(TIME_W-CFG_W){1'b0}}, cfg.reply_timeout});
  assign beat_due = !d_beat[TIME_W-1];
  assign seq_inc = entry.beat_counter + 1'b1;

  always_comb begin
    entry_next = entry;
    upd = '0;
    case (cmd)
      CMD_START: begin
        if (entry.phase == PH_IDLE) begin
          entry_next.phase = PH_CONNECTING;
          entry_next.time_mark = now_ms;
        end
      end
      CMD_DONE: begin
        if (entry.phase == PH_CONNECTING) begin
          entry_next.phase = PH_OPEN;
          entry_next.next_beat = now_ms;
          entry_next.beat_counter = seq_inc;
          entry_next.hb_outstanding = 1'b1;
          entry_next.time_mark = now_ms;
          upd.open_inc = 1'b1;
          upd.action = ACT_BEAT;
          upd.seq = seq_inc;
        end
      end
      CMD_ERROR: begin
        if (entry.phase == PH_IDLE || entry.phase == PH_CONNECTING) begin
          entry_next.phase = PH_FAILED;
          upd.action = ACT_FAILED;
        end
      end
      CMD_REPLY: begin
        if (entry.phase == PH_OPEN) begin
          entry_next.hb_outstanding = 1'b0;
          entry_next.next_beat = now_ms + {{(TIME_W-CFG_W){1'b0}}, cfg.hb_interval};
          if (!entry.backend_valid) begin
            entry_next.backend = reply_backend;
            entry_next.backend_valid = 1'b1;
          end else if (entry.backend != reply_backend) begin
            entry_next.phase = PH_BROKEN;
            upd.open_dec = 1'b1;
            upd.brk = 1'b1;
            upd.action = ACT_BROKEN;
            upd.cause = CAUSE_WRONG_BACKEND;
          end
        end
      end
      CMD_BREAK: begin
        if (entry.phase == PH_OPEN) begin
          entry_next.phase = PH_BROKEN;
          entry_next.hb_outstanding = 1'b0;
          upd.open_dec = 1'b1;
          upd.brk = 1'b1;
          upd.action = ACT_BROKEN;
          upd.cause = break_cause;
        end
      end
      CMD_SCAN: begin
        if (entry.phase == PH_CONNECTING) begin
          if (connect_expired) begin
            entry_next.phase = PH_FAILED;
            upd.action = ACT_FAILED;
          end
        end else if (entry.phase == PH_OPEN) begin
          if (entry.hb_outstanding) begin
            if (reply_expired) begin
              entry_next.phase = PH_BROKEN;
              entry_next.hb_outstanding = 1'b0;
              upd.open_dec = 1'b1;
              upd.brk = 1'b1;
              upd.action = ACT_BROKEN;
              upd.cause = CAUSE_TIMEOUT;
            end
          end else if (beat_due) begin
            entry_next.beat_counter = seq_inc;
            entry_next.hb_outstanding = 1'b1;
            entry_next.time_mark = now_ms;
            upd.action = ACT_BEAT;
            upd.seq = seq_inc;
          end
        end
      end
      default: begin
        upd.cause = CAUSE_RST;
      end
    endcase
  end

endmodule

// ===== rtl/core/connection_liveness_tracker_unit.sv =====
// top level: connection table memory, command sequencing and counters
`timescale 1ns / 1ps

// Tracks the liveness of up to NUM_CONNS connections (at most 1024 are
// addressable through the 10-bit index) in one synchronous table memory.
// Every input transaction names one entry and yields exactly one result
// transaction. Taking a transaction issues the table read; in the execute
// state the entry is updated, written back and the output register loaded.
// A new transaction is taken while the previous result still waits in the
// output register, but its update waits until that register is free. After
// reset the block clears all min(NUM_CONNS, 1024) table entries, one entry a
// cycle, and takes no input meanwhile; configuration writes are taken at any
// time.
module connection_liveness_tracker_unit #(
  parameter int NUM_CONNS = clt_pkg::NUM_CONNS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: conn_index[9:0], now_ms[41:10], reply_backend[57:42],
  //        break_cause[59:58], zero[63:60]
  input  logic [63:0]  s_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: entry_index[9:0], cause[11:10], heartbeat_seq[43:12],
  //        pinned_backend[59:44], backend_known[60], open_total[71:61],
  //        break_tally[103:72]
  output logic [103:0] m_tdata,
  // tuser: action[1:0]
  output logic [1:0]   m_tuser
);
  import clt_pkg::*;

  localparam int DEPTH = (NUM_CONNS < (1 << INDEX_W)) ? NUM_CONNS : (1 << INDEX_W);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = CNT_W + 2;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state;
  logic [AW-1:0] clr_addr;

  cfg_t cfg;

  logic [2:0] item_cmd;
  logic [INDEX_W-1:0] item_index;
  logic [TIME_W-1:0] item_now;
  logic [BACKEND_W-1:0] item_backend;
  logic [1:0] item_cause;

  entry_t mem [DEPTH];
  entry_t rdata;
  entry_t entry_next;
  upd_t upd;

  logic accept;
  logic commit;
  logic in_range;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;

  logic [CNT_W-1:0] cause_cnt [4];
  logic [SUM_W-1:0] broken_sum;
  logic [SUM_W-1:0] broken_sum_next;
  logic [OPEN_W-1:0] live_conns;
  logic [OPEN_W-1:0] live_conns_next;
  logic count_brk;

  logic [1:0] out_action;
  logic [1:0] out_cause;
  logic [SEQ_W-1:0] out_seq;
  logic [BACKEND_W-1:0] out_pinned;
  logic out_known;
  logic [CNT_W-1:0] out_broken;

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign commit = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign in_range = ({{(32-INDEX_W){1'b0}}, item_index} < 32'(NUM_CONNS));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hb_interval <= HB_INTERVAL_RST;
      cfg.reply_timeout <= REPLY_TIMEOUT_RST;
      cfg.connect_timeout <= CONNECT_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HB_INTERVAL:     cfg.hb_interval <= cfg_data;
        REG_REPLY_TIMEOUT:   cfg.reply_timeout <= cfg_data;
        REG_CONNECT_TIMEOUT: cfg.connect_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // captured transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd <= s_tuser;
      item_index <= s_tdata[9:0];
      item_now <= s_tdata[41:10];
      item_backend <= s_tdata[57:42];
      item_cause <= s_tdata[59:58];
    end
  end

  // table memory: one write port, one registered read port
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we = commit && in_range;
      mem_waddr = item_index[AW-1:0];
      mem_wdata = entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[s_tdata[AW-1:0]];
    end
  end

  clt_entry_update u_update (
    .cmd           (item_cmd),
    .now_ms        (item_now),
    .reply_backend (item_backend),
    .break_cause   (item_cause),
    .cfg           (cfg),
    .entry         (rdata),
    .entry_next    (entry_next),
    .upd           (upd)
  );

  // global counters
  assign count_brk = in_range && upd.brk && (cause_cnt[upd.cause] != CNT_MAX);

  always_comb begin
    live_conns_next = live_conns;
    if (in_range && upd.open_inc && live_conns != OPEN_MAX) begin
      live_conns_next = live_conns + 1'b1;
    end else if (in_range && upd.open_dec && live_conns != '0) begin
      live_conns_next = live_conns - 1'b1;
    end
    broken_sum_next = broken_sum + {{(SUM_W-1){1'b0}}, count_brk};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        cause_cnt[k] <= '0;
      end
      broken_sum <= '0;
      live_conns <= '0;
    end else if (commit) begin
      if (count_brk) begin
        cause_cnt[upd.cause] <= cause_cnt[upd.cause] + 1'b1;
      end
      broken_sum <= broken_sum_next;
      live_conns <= live_conns_next;
    end
  end

  // result fields
  always_comb begin
    if (in_range) begin
      out_action = upd.action;
      out_cause = upd.cause;
      out_seq = upd.seq;
      out_known = entry_next.backend_valid;
      out_pinned = entry_next.backend_valid ? entry_next.backend : '0;
    end else begin
      out_action = ACT_NONE;
      out_cause = CAUSE_RST;
      out_seq = '0;
      out_known = 1'b0;
      out_pinned = '0;
    end
    out_broken = (broken_sum_next[SUM_W-1:CNT_W] != '0) ? CNT_MAX
                                                        : broken_sum_next[CNT_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser <= out_action;
      m_tdata <= {out_broken, live_conns_next, out_known, out_pinned, out_seq,
                  out_cause, item_index};
    end
  end

endmodule

// ===== test/liveness_checker.sv =====
// result checker for the connection liveness tracker: predicts every result and compares
`timescale 1ns / 1ps

module liveness_checker #(
  parameter int NUM_CONNS = clt_pkg::NUM_CONNS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // tdata: conn_index[9:0], now_ms[41:10], reply_backend[57:42], break_cause[59:58]
  input  logic [63:0]  s_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // tdata: entry_index[9:0], cause[11:10], heartbeat_seq[43:12], pinned_backend[59:44],
  //        backend_known[60], open_total[71:61], break_tally[103:72]
  input  logic [103:0] m_tdata,
  // tuser: action[1:0]
  input  logic [1:0]   m_tuser,
  output int           mismatches,
  output int           awaited
);
  import clt_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0]   entry;
    logic [1:0]           action;
    logic [1:0]           cause;
    logic [SEQ_W-1:0]     seq;
    logic [BACKEND_W-1:0] pinned;
    logic                 known;
    logic [OPEN_W-1:0]    open_total;
    logic [CNT_W-1:0]     break_tally;
  } tracker_result_t;

  // shadow of the connection table
  logic [2:0]           phase_of     [NUM_CONNS];
  logic [BACKEND_W-1:0] pinned_id    [NUM_CONNS];
  logic                 pin_set      [NUM_CONNS];
  logic                 beat_pending [NUM_CONNS];
  logic [TIME_W-1:0]    mark_ms      [NUM_CONNS];
  logic [TIME_W-1:0]    due_ms       [NUM_CONNS];
  logic [SEQ_W-1:0]     beats_sent   [NUM_CONNS];
  logic [CNT_W-1:0]     per_cause    [4];
  logic [OPEN_W-1:0]    live_open;

  logic [CFG_W-1:0] hb_gap;
  logic [CFG_W-1:0] reply_limit;
  logic [CFG_W-1:0] connect_limit;

  tracker_result_t liveness_outcomes[$];

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    mismatches++;
    $display("%0t ns: %s got %0h want %0h", $time, what, got_v, want_v);
  endtask

  // elapsed only when the difference lies in the lower half of the 32-bit circle
  function automatic logic has_expired(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] mark,
                                       input logic [CFG_W-1:0] limit);
    logic [TIME_W-1:0] d;
    d = now - mark;
    return !d[TIME_W-1] && (d > {16'h0000, limit});
  endfunction

  function automatic logic [CNT_W-1:0] broken_sum();
    logic [CNT_W+1:0] s;
    s = {2'b00, per_cause[0]} + {2'b00, per_cause[1]} + {2'b00, per_cause[2]}
      + {2'b00, per_cause[3]};
    return (s > {2'b00, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic void mark_broken(input logic [INDEX_W-1:0] idx, input logic [1:0] why);
    phase_of[idx] = PH_BROKEN;
    beat_pending[idx] = 1'b0;
    if (per_cause[why] != CNT_MAX) per_cause[why]++;
    if (live_open != '0) live_open--;
  endfunction

  function automatic logic [SEQ_W-1:0] send_beat(input logic [INDEX_W-1:0] idx,
                                                 input logic [TIME_W-1:0] now);
    beats_sent[idx] = beats_sent[idx] + 1'b1;
    beat_pending[idx] = 1'b1;
    mark_ms[idx] = now;
    return beats_sent[idx];
  endfunction

  function automatic tracker_result_t step_liveness(input logic [2:0] cmd,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [TIME_W-1:0] now,
                                                    input logic [BACKEND_W-1:0] rb,
                                                    input logic [1:0] bc);
    tracker_result_t res;
    logic [TIME_W-1:0] since_due;
    res = '0;
    res.entry = idx;
    if (int'(idx) < NUM_CONNS) begin
      case (cmd)
        CMD_START: begin
          if (phase_of[idx] == PH_IDLE) begin
            phase_of[idx] = PH_CONNECTING;
            mark_ms[idx] = now;
          end
        end
        CMD_DONE: begin
          if (phase_of[idx] == PH_CONNECTING) begin
            phase_of[idx] = PH_OPEN;
            if (live_open != OPEN_MAX) live_open++;
            due_ms[idx] = now;
            res.seq = send_beat(idx, now);
            res.action = ACT_BEAT;
          end
        end
        CMD_ERROR: begin
          if (phase_of[idx] == PH_IDLE || phase_of[idx] == PH_CONNECTING) begin
            phase_of[idx] = PH_FAILED;
            res.action = ACT_FAILED;
          end
        end
        CMD_REPLY: begin
          if (phase_of[idx] == PH_OPEN) begin
            beat_pending[idx] = 1'b0;
            due_ms[idx] = now + {16'h0000, hb_gap};
            if (!pin_set[idx]) begin
              pinned_id[idx] = rb;
              pin_set[idx] = 1'b1;
            end else if (pinned_id[idx] != rb) begin
              mark_broken(idx, CAUSE_WRONG_BACKEND);
              res.action = ACT_BROKEN;
              res.cause = CAUSE_WRONG_BACKEND;
            end
          end
        end
        CMD_BREAK: begin
          if (phase_of[idx] == PH_OPEN) begin
            mark_broken(idx, bc);
            res.action = ACT_BROKEN;
            res.cause = bc;
          end
        end
        CMD_SCAN: begin
          if (phase_of[idx] == PH_CONNECTING) begin
            if (has_expired(now, mark_ms[idx], connect_limit)) begin
              phase_of[idx] = PH_FAILED;
              res.action = ACT_FAILED;
            end
          end else if (phase_of[idx] == PH_OPEN) begin
            since_due = now - due_ms[idx];
            if (beat_pending[idx]) begin
              if (has_expired(now, mark_ms[idx], reply_limit)) begin
                mark_broken(idx, CAUSE_TIMEOUT);
                res.action = ACT_BROKEN;
                res.cause = CAUSE_TIMEOUT;
              end
            end else if (!since_due[TIME_W-1]) begin
              res.seq = send_beat(idx, now);
              res.action = ACT_BEAT;
            end
          end
        end
        default: ;
      endcase
      if (pin_set[idx]) begin
        res.known = 1'b1;
        res.pinned = pinned_id[idx];
      end
    end
    res.open_total = live_open;
    res.break_tally = broken_sum();
    return res;
  endfunction

  always @(posedge clk) begin : watch
    tracker_result_t got;
    tracker_result_t want;
    int k;
    if (rst) begin
      for (k = 0; k < NUM_CONNS; k++) begin
        phase_of[k] = PH_IDLE;
        pinned_id[k] = '0;
        pin_set[k] = 1'b0;
        beat_pending[k] = 1'b0;
        mark_ms[k] = '0;
        due_ms[k] = '0;
        beats_sent[k] = '0;
      end
      for (k = 0; k < 4; k++) per_cause[k] = '0;
      live_open = '0;
      hb_gap = HB_INTERVAL_RST;
      reply_limit = REPLY_TIMEOUT_RST;
      connect_limit = CONNECT_TIMEOUT_RST;
      liveness_outcomes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HB_INTERVAL:     hb_gap = cfg_data;
          REG_REPLY_TIMEOUT:   reply_limit = cfg_data;
          REG_CONNECT_TIMEOUT: connect_limit = cfg_data;
          default: ;
        endcase
      end
      // a result never belongs to a transaction taken at the same edge
      if (m_tvalid && m_tready) begin
        got.entry = m_tdata[9:0];
        got.cause = m_tdata[11:10];
        got.seq = m_tdata[43:12];
        got.pinned = m_tdata[59:44];
        got.known = m_tdata[60];
        got.open_total = m_tdata[71:61];
        got.break_tally = m_tdata[103:72];
        got.action = m_tuser;
        if (liveness_outcomes.size() == 0) begin
          report_mismatch("result with nothing outstanding, entry", 32'(got.entry), '0);
        end else begin
          want = liveness_outcomes.pop_front();
          if (got.entry != want.entry)
            report_mismatch("entry_index", 32'(got.entry), 32'(want.entry));
          if (got.action != want.action)
            report_mismatch("action", 32'(got.action), 32'(want.action));
          if (got.cause != want.cause)
            report_mismatch("cause", 32'(got.cause), 32'(want.cause));
          if (got.seq != want.seq) report_mismatch("heartbeat_seq", got.seq, want.seq);
          if (got.pinned != want.pinned)
            report_mismatch("pinned_backend", 32'(got.pinned), 32'(want.pinned));
          if (got.known != want.known)
            report_mismatch("backend_known", 32'(got.known), 32'(want.known));
          if (got.open_total != want.open_total)
            report_mismatch("open_total", 32'(got.open_total), 32'(want.open_total));
          if (got.break_tally != want.break_tally)
            report_mismatch("break_tally", got.break_tally, want.break_tally);
        end
      end
      if (s_tvalid && s_tready)
        liveness_outcomes.push_back(step_liveness(s_tuser, s_tdata[9:0], s_tdata[41:10],
                                                  s_tdata[57:42], s_tdata[59:58]));
    end
    awaited = liveness_outcomes.size();
  end

endmodule

// ===== test/tb_top.sv =====
// top of the connection liveness tracker testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import clt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SLOTS = 8;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 290;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [1:0] REG_SPARE = 2'd3;

  // how far the stimulus has taken a tracked connection
  localparam int STAGE_FRESH = 0;
  localparam int STAGE_CONNECTING = 1;
  localparam int STAGE_OPEN = 2;
  localparam int STAGE_SPENT = 3;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // tdata: conn_index[9:0], now_ms[41:10], reply_backend[57:42], break_cause[59:58]
  logic [63:0]  s_tdata = '0;
  // tuser: cmd[2:0]
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // tdata: entry_index[9:0], cause[11:10], heartbeat_seq[43:12], pinned_backend[59:44],
  //        backend_known[60], open_total[71:61], break_tally[103:72]
  logic [103:0] m_tdata;
  // tuser: action[1:0]
  logic [1:0]   m_tuser;

  int   mismatches;
  int   awaited;
  int   cycle_count = 0;
  int   stall_left = 0;
  logic sink_steady = 1'b0;
  bit   burst_send = 1'b0;

  int          slot_entry   [SLOTS];
  int          slot_stage   [SLOTS];
  int          slot_life    [SLOTS];
  logic [15:0] slot_backend [SLOTS];

  always #10 clk = ~clk;

  connection_liveness_tracker_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  liveness_checker tracker_watch (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin : sink_pacing
    int roll;
    roll = $urandom_range(0, 99);
    if (sink_steady) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (roll < 20) stall_left <= $urandom_range(1, 3);
      else if (roll < 23) stall_left <= $urandom_range(15, 60);
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [9:0] idx,
                              input logic [31:0] now, input logic [15:0] rb,
                              input logic [1:0] bc);
    int gap;
    int roll;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'b0000, bc, rb, now, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    roll = $urandom_range(0, 99);
    if (burst_send || roll < 65) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // lets every outstanding transaction come out
  task automatic drain_tracker();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int          phase;
    int          n;
    int          s;
    int          r;
    int          next_fresh;
    logic [31:0] t0;
    logic [31:0] wall_ms;
    logic [31:0] now;
    logic [15:0] hb;
    logic [15:0] rt;
    logic [15:0] ct;
    logic [15:0] rb;
    logic [2:0]  cmd;
    logic [9:0]  idx;
    logic [1:0]  bc;
    bit          spare;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, times chosen to wrap past zero
    t0 = 32'hFFFF_FF00;
    send_command(CMD_START, 10'd0, t0, 16'($urandom()), 2'd0);
    // exactly at the connect timeout: still pending
    send_command(CMD_SCAN, 10'd0, t0 + 32'd5000, 16'($urandom()), 2'd1);
    send_command(CMD_DONE, 10'd0, t0 + 32'd5000, 16'($urandom()), 2'd2);
    send_command(CMD_REPLY, 10'd0, t0 + 32'd5010, 16'hFFFF, 2'd3);
    send_command(CMD_REPLY, 10'd0, t0 + 32'd5020, 16'hFFFF, 2'd0);
    send_command(CMD_SCAN, 10'd0, t0 + 32'd5119, 16'($urandom()), 2'd0);
    send_command(CMD_SCAN, 10'd0, t0 + 32'd5120, 16'($urandom()), 2'd0);
    send_command(CMD_SCAN, 10'd0, t0 + 32'd7121, 16'($urandom()), 2'd0);
    // a broken entry cannot start again
    send_command(CMD_START, 10'd0, t0 + 32'd7200, 16'($urandom()), 2'd0);
    send_command(CMD_SPARE_6, 10'd1, t0 + 32'd7210, 16'($urandom()), 2'd3);
    send_command(CMD_SPARE_7, 10'd1, t0 + 32'd7220, 16'($urandom()), 2'd3);
    send_command(CMD_START, 10'd1023, t0 + 32'd7300, 16'($urandom()), 2'd0);
    send_command(CMD_DONE, 10'd1023, t0 + 32'd7310, 16'($urandom()), 2'd0);
    send_command(CMD_REPLY, 10'd1023, t0 + 32'd7320, 16'h0000, 2'd0);
    send_command(CMD_REPLY, 10'd1023, t0 + 32'd7330, 16'h0001, 2'd0);
    send_command(CMD_START, 10'd2, t0 + 32'd7400, 16'($urandom()), 2'd0);
    send_command(CMD_SCAN, 10'd2, t0 + 32'd12401, 16'($urandom()), 2'd0);
    send_command(CMD_ERROR, 10'd3, t0 + 32'd12500, 16'($urandom()), 2'd0);
    send_command(CMD_START, 10'd4, t0 + 32'd12600, 16'($urandom()), 2'd0);
    send_command(CMD_ERROR, 10'd4, t0 + 32'd12610, 16'($urandom()), 2'd0);
    send_command(CMD_START, 10'd5, t0 + 32'd12700, 16'($urandom()), 2'd0);
    send_command(CMD_DONE, 10'd5, t0 + 32'd12710, 16'($urandom()), 2'd0);
    // break cause three is counted as a wrong backend
    send_command(CMD_BREAK, 10'd5, t0 + 32'd12720, 16'($urandom()), 2'd3);

    wall_ms = t0 + 32'd13000;
    next_fresh = 6;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain_tracker();
        spare = 1'b0;
        case (phase)
          1: begin
            hb = 16'd1; rt = 16'd1; ct = 16'd1;
          end
          2: begin
            hb = 16'hFFFF; rt = 16'hFFFF; ct = 16'hFFFF;
          end
          3: begin
            hb = 16'($urandom_range(1, 65535));
            rt = 16'($urandom_range(1, 65535));
            ct = 16'($urandom_range(1, 65535));
            spare = 1'b1;
          end
          4: begin
            hb = 16'd1; rt = 16'hFFFF; ct = 16'hFFFF;
          end
          default: begin
            hb = 16'($urandom_range(1, 300));
            rt = 16'($urandom_range(1, 300));
            ct = 16'($urandom_range(1, 300));
          end
        endcase
        cfg_we <= 1'b1;
        cfg_index <= REG_HB_INTERVAL;
        cfg_data <= hb;
        @(posedge clk);
        cfg_index <= REG_REPLY_TIMEOUT;
        cfg_data <= rt;
        @(posedge clk);
        cfg_index <= REG_CONNECT_TIMEOUT;
        cfg_data <= ct;
        @(posedge clk);
        if (spare) begin
          cfg_index <= REG_SPARE;
          cfg_data <= 16'($urandom());
          @(posedge clk);
        end
        cfg_we <= 1'b0;
      end

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        burst_send = (n >= 100 && n < 160);
        sink_steady <= (n >= 130 && n < 210);

        // time mostly creeps, sometimes leaps far ahead or steps back
        r = $urandom_range(0, 99);
        if (r < 50) wall_ms += 32'($urandom_range(0, 30));
        else if (r < 80) wall_ms += 32'($urandom_range(0, 300));
        else if (r < 93) wall_ms += 32'($urandom_range(0, 6000));
        else if (r < 97) wall_ms += 32'($urandom_range(60000, 70000));
        else if (r < 99) wall_ms -= 32'($urandom_range(1, 50));
        else wall_ms += $urandom();

        now = wall_ms;
        rb = 16'($urandom());
        bc = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // noise on any entry
          cmd = 3'($urandom_range(0, 7));
          idx = 10'($urandom_range(0, 1023));
          if (r < 3) now = $urandom();
        end else begin
          s = $urandom_range(0, SLOTS - 1);
          if (slot_life[s] == 0) begin
            if (next_fresh < 1023) begin
              slot_entry[s] = next_fresh;
              next_fresh++;
            end else begin
              slot_entry[s] = $urandom_range(0, 1023);
            end
            slot_stage[s] = STAGE_FRESH;
            slot_life[s] = $urandom_range(3, 30);
            slot_backend[s] = 16'($urandom());
          end
          idx = 10'(slot_entry[s]);
          slot_life[s]--;
          r = $urandom_range(0, 99);
          case (slot_stage[s])
            STAGE_FRESH: begin
              cmd = CMD_START;
              slot_stage[s] = STAGE_CONNECTING;
            end
            STAGE_CONNECTING: begin
              if (r < 15) begin
                cmd = CMD_SCAN;
              end else if (r < 25) begin
                cmd = CMD_ERROR;
                slot_stage[s] = STAGE_SPENT;
              end else begin
                cmd = CMD_DONE;
                slot_stage[s] = STAGE_OPEN;
              end
            end
            STAGE_OPEN: begin
              if (r < 45) begin
                cmd = CMD_REPLY;
                rb = (r < 3) ? slot_backend[s] ^ 16'($urandom_range(1, 65535))
                             : slot_backend[s];
              end else if (r < 87) begin
                cmd = CMD_SCAN;
              end else if (r < 94) begin
                cmd = CMD_BREAK;
                slot_stage[s] = STAGE_SPENT;
              end else begin
                cmd = 3'($urandom_range(0, 7));
              end
            end
            default: cmd = 3'($urandom_range(0, 7));
          endcase
          // little point lingering on a dead entry
          if (slot_stage[s] == STAGE_SPENT && slot_life[s] > 2) slot_life[s] = 2;
        end
        send_command(cmd, idx, now, rb, bc);
      end
    end

    drain_tracker();
    repeat (6) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/clt_pkg.sv
rtl/core/clt_entry_update.sv
rtl/core/connection_liveness_tracker_unit.sv
test/liveness_checker.sv
test/tb_top.sv
